// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the crc combine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define CCE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define CCE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hdl/crc_comb_pkg.sv -----
// Package: types, constants and helpers of the crc combine engine.
`default_nettype none

package crc_comb_pkg;

  localparam int CRC_W           = 64;  // wide mode width
  localparam int NARROW_W        = 32;  // narrow mode width
  localparam int DIGIT_W         = 4;   // multiplier bits retired per cycle
  localparam int LEN_W           = 29;  // second_length port width
  localparam int LENGTH_BITS_DEF = 29;
  localparam int CFG_IDX_W       = 2;

  localparam int STEP_CNT_W = $clog2(CRC_W / DIGIT_W);
  localparam logic [STEP_CNT_W-1:0] WIDE_LAST   = STEP_CNT_W'(CRC_W / DIGIT_W - 1);
  localparam logic [STEP_CNT_W-1:0] NARROW_LAST = STEP_CNT_W'(NARROW_W / DIGIT_W - 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NPOLY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WPOLY = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_FINAL = 4'b1000
  } state_e;

  // Control handed to a mulmod unit
  typedef struct packed {
    logic start;
    logic wide;
  } mul_ctl_t;

  // One multiply-by-x step in the reflected domain
  function automatic logic [CRC_W-1:0] gf_step(input logic [CRC_W-1:0] v,
                                               input logic [CRC_W-1:0] p);
    return (v >> 1) ^ (v[0] ? p : '0);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/crc_comb_mulmod.sv -----
// Digit-serial GF(2) multiply modulo P, reflected domain, 4 bits per cycle.
`default_nettype none

`include "assert_macros.svh"

module crc_comb_mulmod import crc_comb_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire mul_ctl_t         ctl_i,
  input  wire logic [CRC_W-1:0] a_i,
  input  wire logic [CRC_W-1:0] b_i,
  input  wire logic [CRC_W-1:0] poly_i,
  output logic      [CRC_W-1:0] prod_o,
  output logic                  done_o
);

  logic [CRC_W-1:0]      a_q, b_q, prod_q;
  logic [CRC_W-1:0]      b_w, p_w;
  logic [STEP_CNT_W-1:0] cnt_q;
  logic                  run_q, done_q;

  // a is scanned from its top bit (x^0 coefficient) down, one digit a cycle
  always_comb begin
    b_w = b_q;
    p_w = prod_q;
    for (int j = 0; j < DIGIT_W; j++) begin
      if (a_q[CRC_W-1-j]) begin
        p_w = p_w ^ b_w;
      end
      b_w = gf_step(b_w, poly_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= run_q && (cnt_q == '0);
      if (ctl_i.start) begin
        run_q <= 1'b1;
        cnt_q <= ctl_i.wide ? WIDE_LAST : NARROW_LAST;
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      // narrow operands are top-aligned so the scan always starts at bit 63
      a_q    <= ctl_i.wide ? a_i : (a_i << NARROW_W);
      b_q    <= b_i;
      prod_q <= '0;
    end else if (run_q) begin
      a_q    <= a_q << DIGIT_W;
      b_q    <= b_w;
      prod_q <= p_w;
    end
  end

  assign prod_o = prod_q;
  assign done_o = done_q;

  `CCE_ASSERT(a_no_restart, ctl_i.start |-> !run_q, "mulmod started while running")
  `CCE_ASSERT(a_done_idle, done_q |-> !run_q, "mulmod done while still running")
  `CCE_ASSERT(a_last_done, (run_q && cnt_q == '0 && !ctl_i.start) |=> done_q,
              "mulmod last digit gave no done")

endmodule

`default_nettype wire

// ----- hdl/crc_combine_engine.sv -----
// Top level: CRC combine engine, x^(8*len) mod P by square-and-multiply.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+--------------------------------------
//  command   | in        | start / busy            | first_crc_i, second_crc_i,
//            |           |                         | second_length_i
//  result    | out       | done_o (1-cycle strobe) | combined_crc_o
//  config    | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Passes: with m the bit length of 8*second_length, an item runs m square-and-multiply
//   passes, then one final acc*crc1 pass, on the two 4-bit digit-serial mulmod units
//   (64 bits wide, 32 narrow).
// Reset clears the sequencer and the config regs (wide mode, zero polynomials).
// One item at a time: busy stays high from accept until the result cycle.
// The receiver cannot stall; the result is shown for one cycle only.
`default_nettype none

`include "assert_macros.svh"

module crc_combine_engine import crc_comb_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // command
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [CRC_W-1:0]     first_crc_i,
  input  wire logic [CRC_W-1:0]     second_crc_i,
  input  wire logic [LEN_W-1:0]     second_length_i,
  // result
  output logic                      done_o,
  output logic [CRC_W-1:0]          combined_crc_o,
  // config
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CRC_W-1:0]     cfg_data_i
);

  // bit count n = 8*len: three extra low bits
  localparam int N_W = LENGTH_BITS + 3;

  state_e state_q, state_d;

  logic                wide_q;
  logic [NARROW_W-1:0] npoly_q;
  logic [CRC_W-1:0]    wpoly_q;
  logic [CRC_W-1:0]    poly_w;

  logic [N_W-1:0]   n_q;
  logic [CRC_W-1:0] acc_q, pow_q, crc1_q, crc2_q, res_q;
  logic             done_q;
  logic             n_zero;

  mul_ctl_t         mul_ctl;
  logic [CRC_W-1:0] mul_a_b;
  logic [CRC_W-1:0] mul_a_prod, mul_b_prod;
  logic             mul_a_done, mul_b_done;

  logic             accept;
  logic [CRC_W-1:0] top_w;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign n_zero      = (n_q == '0);

  assign poly_w = wide_q ? wpoly_q : {{(CRC_W-NARROW_W){1'b0}}, npoly_q};
  // x^0 in the reflected domain sits at the top bit of the active width
  assign top_w  = wide_q ? {1'b1, {(CRC_W-1){1'b0}}}
                         : {{(CRC_W-NARROW_W){1'b0}}, 1'b1, {(NARROW_W-1){1'b0}}};

  // config writes: by contract the user writes them only while idle; the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q  <= 1'b1;
      npoly_q <= '0;
      wpoly_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MODE:  wide_q  <= cfg_data_i[0];
        CFG_NPOLY: npoly_q <= cfg_data_i[NARROW_W-1:0];
        CFG_WPOLY: wpoly_q <= cfg_data_i;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // sequencer: ISSUE starts one square (and multiply) pass per bit of n,
  // or the final acc*crc1 pass once n is exhausted
  always_comb begin
    state_d       = state_q;
    mul_ctl.start = 1'b0;
    mul_ctl.wide  = wide_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_ISSUE;
      end
      ST_ISSUE: begin
        mul_ctl.start = 1'b1;
        state_d       = n_zero ? ST_FINAL : ST_RUN;
      end
      ST_RUN: begin
        if (mul_b_done) state_d = ST_ISSUE;
      end
      ST_FINAL: begin
        if (mul_a_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_FINAL) && mul_a_done;
    end
  end

  // datapath regs, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      crc1_q <= wide_q ? first_crc_i  : {{(CRC_W-NARROW_W){1'b0}}, first_crc_i[NARROW_W-1:0]};
      crc2_q <= wide_q ? second_crc_i : {{(CRC_W-NARROW_W){1'b0}}, second_crc_i[NARROW_W-1:0]};
      n_q    <= {second_length_i[LENGTH_BITS-1:0], 3'b000};
      acc_q  <= top_w;
      pow_q  <= top_w >> 1;
    end else if ((state_q == ST_RUN) && mul_b_done) begin
      if (n_q[0]) acc_q <= mul_a_prod;
      pow_q <= mul_b_prod;
      n_q   <= n_q >> 1;
    end
    if ((state_q == ST_FINAL) && mul_a_done) begin
      res_q <= mul_a_prod ^ crc2_q;
    end
  end

  // unit A: acc*power during the loop, acc*crc1 at the end
  assign mul_a_b = n_zero ? crc1_q : pow_q;

  crc_comb_mulmod u_mul_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mul_ctl),
    .a_i    (acc_q),
    .b_i    (mul_a_b),
    .poly_i (poly_w),
    .prod_o (mul_a_prod),
    .done_o (mul_a_done)
  );

  // unit B: power squared
  crc_comb_mulmod u_mul_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mul_ctl),
    .a_i    (pow_q),
    .b_i    (pow_q),
    .poly_i (poly_w),
    .prod_o (mul_b_prod),
    .done_o (mul_b_done)
  );

  assign done_o         = done_q;
  assign combined_crc_o = res_q;

  `CCE_ASSERT(a_accept_busy, accept |=> busy, "accepted beat did not raise busy")
  `CCE_ASSERT(a_strobe_single, done_o |=> !done_o, "result strobe longer than one cycle")
  `CCE_ASSERT(a_strobe_idle, done_o |-> !busy, "result strobe while still busy")
  `CCE_ASSERT(a_units_lockstep, mul_a_done == mul_b_done, "mulmod units out of step")

endmodule

`default_nettype wire
